### src/hhs_pkg.sv
`default_nettype none
package hhs_pkg;

    localparam int unsigned CNT_W    = 16;
    localparam int unsigned TEMP_W   = 10;
    localparam int unsigned EBASE_W  = 15;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [TEMP_W-1:0] COOL_TEMP = 10'd70;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 16'hFFFF;

    localparam logic             RST_SLEEP_EN    = 1'b1;
    localparam logic [CNT_W-1:0] RST_SLEEP_DELAY = 16'd60000;
    localparam logic [TEMP_W-1:0] RST_MAX_TEMP   = 10'd550;
    localparam logic [TEMP_W-1:0] RST_MIN_TEMP   = 10'd50;
    localparam logic [TEMP_W-1:0] RST_MIN_AIR    = 10'd10;
    localparam logic [EBASE_W-1:0] RST_ERR_BASE  = 15'd1000;
    localparam logic [CNT_W-1:0] RST_SETTLE      = 16'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLEEP_EN    = 3'd0,
        CFG_SLEEP_DELAY = 3'd1,
        CFG_MAX_TEMP    = 3'd2,
        CFG_MIN_TEMP    = 3'd3,
        CFG_MIN_AIR     = 3'd4,
        CFG_ERR_BASE    = 3'd5,
        CFG_SETTLE      = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        MODE_SLEEP = 1'b0,
        MODE_WORK  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        FAULT_OK   = 2'd0,
        FAULT_OVER = 2'd1,
        FAULT_LOW  = 2'd2,
        FAULT_FAN  = 2'd3
    } t_fault;

    typedef struct packed {
        logic               sleep_en;
        logic [CNT_W-1:0]   sleep_delay;
        logic [TEMP_W-1:0]  max_temp;
        logic [TEMP_W-1:0]  min_temp;
        logic [TEMP_W-1:0]  min_air;
        logic [EBASE_W-1:0] err_base;
        logic [CNT_W-1:0]   settle;
    } t_cfg;

    typedef struct packed {
        logic              handle_lifted;
        logic [TEMP_W-1:0] heater_temp;
        logic [TEMP_W-1:0] airflow;
    } t_item;

    typedef struct packed {
        t_mode  working;
        t_fault fault_code;
        logic   relay_closed;
        logic   heater_ready;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

endpackage
`default_nettype wire

### src/hhs_if.sv
`default_nettype none
interface hhs_in_if;
    logic       valid;
    logic       ready;
    logic       handle_lifted;
    logic [9:0] heater_temp;
    logic [9:0] airflow;

    modport source (output valid, handle_lifted, heater_temp, airflow, input ready);
    modport sink   (input valid, handle_lifted, heater_temp, airflow, output ready);
endinterface

interface hhs_out_if;
    logic       valid;
    logic       ready;
    logic       working;
    logic [1:0] fault_code;
    logic       relay_closed;
    logic       heater_ready;

    modport source (output valid, working, fault_code, relay_closed, heater_ready,
                    input ready);
    modport sink   (input valid, working, fault_code, relay_closed, heater_ready,
                    output ready);
endinterface
`default_nettype wire

### src/hhs_core.sv
`default_nettype none
module hhs_core
    import hhs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    t_mode             r_mode,        n_mode;
    logic [CNT_W-1:0]  r_sleep_cnt,   n_sleep_cnt;
    logic [CNT_W-1:0]  r_fault_cnt,   n_fault_cnt;
    logic              r_fault_latch, n_fault_latch;
    t_fault            r_fault_kind,  n_fault_kind;
    logic              r_relay,       n_relay;
    logic              r_ready,       n_ready;
    logic [CNT_W-1:0]  r_settle,      n_settle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_SLEEP;
            r_sleep_cnt   <= '0;
            r_fault_cnt   <= '0;
            r_fault_latch <= 1'b0;
            r_fault_kind  <= FAULT_OK;
            r_relay       <= 1'b0;
            r_ready       <= 1'b0;
            r_settle      <= RST_SETTLE;
        end else if (i_accept) begin
            r_mode        <= n_mode;
            r_sleep_cnt   <= n_sleep_cnt;
            r_fault_cnt   <= n_fault_cnt;
            r_fault_latch <= n_fault_latch;
            r_fault_kind  <= n_fault_kind;
            r_relay       <= n_relay;
            r_ready       <= n_ready;
            r_settle      <= n_settle;
        end
    end

    always_comb begin
        logic             lifted;
        logic             rest_sleep;
        logic [CNT_W-1:0] sc_inc;
        logic [CNT_W-1:0] fc_mode;
        logic [CNT_W-1:0] fc_inc;
        t_fault           kind;
        logic             trip;

        lifted     = i_item.handle_lifted;
        rest_sleep = !lifted && i_cfg.sleep_en;

        // mode machine
        n_mode      = r_mode;
        n_sleep_cnt = r_sleep_cnt;
        fc_mode     = r_fault_cnt;
        sc_inc      = sat_inc(r_sleep_cnt);
        unique case (r_mode)
            MODE_SLEEP: begin
                if (!rest_sleep) begin
                    n_mode = MODE_WORK;
                end
                fc_mode = '0;
            end
            MODE_WORK: begin
                if (rest_sleep && (i_item.heater_temp <= COOL_TEMP)) begin
                    if (sc_inc > i_cfg.sleep_delay) begin
                        n_mode      = MODE_SLEEP;
                        n_sleep_cnt = '0;
                    end else begin
                        n_sleep_cnt = sc_inc;
                    end
                end
            end
            default: begin
                n_mode = MODE_SLEEP;
            end
        endcase

        // fault monitor
        n_fault_cnt   = fc_mode;
        n_fault_latch = r_fault_latch;
        n_fault_kind  = r_fault_kind;
        fc_inc        = sat_inc(fc_mode);
        if (i_item.heater_temp >= i_cfg.max_temp) begin
            kind = FAULT_OVER;
        end else if (i_item.heater_temp <= i_cfg.min_temp) begin
            kind = FAULT_LOW;
        end else if (i_item.airflow < i_cfg.min_air) begin
            kind = FAULT_FAN;
        end else begin
            kind = FAULT_OK;
        end
        if (kind == FAULT_OVER) begin
            trip = fc_inc > {2'b0, i_cfg.err_base[EBASE_W-1:1]};
        end else begin
            trip = fc_inc > {i_cfg.err_base, 1'b0};
        end
        if (r_fault_latch) begin
            if (rest_sleep) begin
                n_fault_kind  = FAULT_OK;
                n_fault_cnt   = '0;
                n_fault_latch = 1'b0;
            end
        end else if (rest_sleep || kind == FAULT_OK) begin
            n_fault_cnt = '0;
        end else if (trip) begin
            n_fault_kind  = kind;
            n_fault_latch = 1'b1;
            n_fault_cnt   = '0;
        end else begin
            n_fault_cnt = fc_inc;
        end

        // relay and settle countdown
        n_relay  = r_relay;
        n_ready  = r_ready;
        n_settle = r_settle;
        if (n_mode == MODE_SLEEP || n_fault_kind != FAULT_OK) begin
            n_relay  = 1'b0;
            n_ready  = 1'b0;
            n_settle = i_cfg.settle;
        end else if (lifted) begin
            n_relay = 1'b1;
            if (!r_ready) begin
                if (r_settle <= 16'd1) begin
                    n_ready  = 1'b1;
                    n_settle = i_cfg.settle;
                end else begin
                    n_settle = r_settle - 16'd1;
                end
            end
        end

        o_result.working      = n_mode;
        o_result.fault_code   = n_fault_kind;
        o_result.relay_closed = n_relay;
        o_result.heater_ready = n_ready;
    end

endmodule
`default_nettype wire

### src/heater_handle_supervisor.sv
`default_nettype none
// channel  dir  fields                                          bits
// i_in     in   handle_lifted, heater_temp, airflow              1, 10, 10
// o_out    out  working, fault_code, relay_closed, heater_ready  1, 2, 1, 1
// i_cfg_*  in   we, idx (register index), wdata                  1, 3, 16
//
// One beat in per cycle while i_in.ready is high; its result is registered
// and valid the next cycle if the output entry is free, else it waits in the
// skid. With two entries (register plus skid), ready drops only when both are
// full. Synchronous active-low reset restores register defaults, clears state.
module heater_handle_supervisor
    import hhs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    hhs_in_if.sink                    i_in,
    hhs_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    t_item   item;
    t_result result;
    t_result r_out,        n_out;
    t_result r_skid,       n_skid;
    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    logic    in_acc;
    logic    out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sleep_en    <= RST_SLEEP_EN;
            r_cfg.sleep_delay <= RST_SLEEP_DELAY;
            r_cfg.max_temp    <= RST_MAX_TEMP;
            r_cfg.min_temp    <= RST_MIN_TEMP;
            r_cfg.min_air     <= RST_MIN_AIR;
            r_cfg.err_base    <= RST_ERR_BASE;
            r_cfg.settle      <= RST_SETTLE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SLEEP_EN:    r_cfg.sleep_en    <= i_cfg_wdata[0];
                CFG_SLEEP_DELAY: r_cfg.sleep_delay <= i_cfg_wdata;
                CFG_MAX_TEMP:    r_cfg.max_temp    <= i_cfg_wdata[TEMP_W-1:0];
                CFG_MIN_TEMP:    r_cfg.min_temp    <= i_cfg_wdata[TEMP_W-1:0];
                CFG_MIN_AIR:     r_cfg.min_air     <= i_cfg_wdata[TEMP_W-1:0];
                CFG_ERR_BASE:    r_cfg.err_base    <= i_cfg_wdata[EBASE_W-1:0];
                CFG_SETTLE:      r_cfg.settle      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign item.handle_lifted = i_in.handle_lifted;
    assign item.heater_temp   = i_in.heater_temp;
    assign item.airflow       = i_in.airflow;

    assign i_in.ready = !r_skid_valid;
    assign in_acc     = i_in.valid && !r_skid_valid;
    assign out_take   = r_out_valid && o_out.ready;

    hhs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (in_acc) begin
                n_out = result;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_acc) begin
            if (r_out_valid) begin
                n_skid       = result;
                n_skid_valid = 1'b1;
            end else begin
                n_out       = result;
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.working      = r_out.working;
    assign o_out.fault_code   = r_out.fault_code;
    assign o_out.relay_closed = r_out.relay_closed;
    assign o_out.heater_ready = r_out.heater_ready;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_ready_implies_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.heater_ready) |-> r_out.relay_closed)
        else $error("heater ready with relay open");

    a_relay_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.relay_closed) |->
            (r_out.working == MODE_WORK && r_out.fault_code == FAULT_OK))
        else $error("relay closed while sleeping or faulted");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_skid_valid && !o_out.ready) |=> $stable(r_skid))
        else $error("skid entry overwritten");

endmodule
`default_nettype wire
